[design/wsfd_pkg.sv]
`timescale 1ns / 1ps

package wsfd_pkg;

    // Default depth of the queue between the parser and the output stage
    localparam int QUEUE_DEPTH_DEF = 4;

    // Length codes in the second header byte
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Byte counts of the extended length and key fields
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // One classified request handed from the parser to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       has_data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } t_entry;

endpackage

[design/wsfd_front.sv]
`timescale 1ns / 1ps

module wsfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output wsfd_pkg::t_entry    o_entry
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_remaining, n_remaining;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_idx, n_idx;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;

    logic        len_done;
    logic        len_masked;
    logic [63:0] len_value;
    logic [3:0]  left_dec;
    logic [63:0] ext_shift;
    logic [7:0]  key_sel;

    assign left_dec  = r_left - 4'd1;
    assign ext_shift = {r_remaining[55:0], i_byte};

    // Pick the key byte for the current payload position
    always_comb begin
        case (r_idx)
            2'd0:    key_sel = r_key[31:24];
            2'd1:    key_sel = r_key[23:16];
            2'd2:    key_sel = r_key[15:8];
            default: key_sel = r_key[7:0];
        endcase
    end

    // Classify the byte and advance the parse state
    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_remaining = r_remaining;
        n_key       = r_key;
        n_idx       = r_idx;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        len_done    = 1'b0;
        len_masked  = r_masked;
        len_value   = r_remaining;
        o_push          = 1'b0;
        o_entry.data    = 8'd0;
        o_entry.key     = 8'd0;
        o_entry.has_data = 1'b0;
        o_entry.opcode  = r_opcode;
        o_entry.fin     = r_fin;
        o_entry.last    = 1'b1;

        if (i_take) begin
            case (r_phase)
                PH_HDR1: begin
                    n_masked    = i_byte[7];
                    n_remaining = 64'd0;
                    if (i_byte[6:0] == wsfd_pkg::LEN_CODE_16) begin
                        n_left  = wsfd_pkg::EXT16_BYTES;
                        n_phase = PH_EXTLEN;
                    end else if (i_byte[6:0] == wsfd_pkg::LEN_CODE_64) begin
                        n_left  = wsfd_pkg::EXT64_BYTES;
                        n_phase = PH_EXTLEN;
                    end else begin
                        n_remaining = {57'd0, i_byte[6:0]};
                        len_done    = 1'b1;
                        len_masked  = i_byte[7];
                        len_value   = {57'd0, i_byte[6:0]};
                    end
                end
                PH_EXTLEN: begin
                    n_remaining = ext_shift;
                    n_left      = left_dec;
                    if (left_dec == 4'd0) begin
                        len_done  = 1'b1;
                        len_value = ext_shift;
                    end
                end
                PH_KEY: begin
                    n_key  = {r_key[23:0], i_byte};
                    n_left = left_dec;
                    if (left_dec == 4'd0) begin
                        n_idx = 2'd0;
                        if (r_remaining == 64'd0) begin
                            n_phase = PH_HDR0;
                            o_push  = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_idx       = r_idx + 2'd1;
                    n_remaining = r_remaining - 64'd1;
                    o_push           = 1'b1;
                    o_entry.data     = i_byte;
                    o_entry.key      = r_masked ? key_sel : 8'd0;
                    o_entry.has_data = 1'b1;
                    o_entry.last     = (r_remaining == 64'd1);
                    if (r_remaining == 64'd1) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase

            // Length known: go to key, payload, or close an empty frame
            if (len_done) begin
                n_idx = 2'd0;
                if (len_masked) begin
                    n_left  = wsfd_pkg::KEY_BYTES;
                    n_phase = PH_KEY;
                end else if (len_value == 64'd0) begin
                    n_phase = PH_HDR0;
                    o_push  = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_left      <= 4'd0;
            r_remaining <= 64'd0;
            r_key       <= 32'd0;
            r_idx       <= 2'd0;
            r_fin       <= 1'b0;
            r_opcode    <= 4'd0;
            r_masked    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_remaining <= n_remaining;
            r_key       <= n_key;
            r_idx       <= n_idx;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
        end
    end

endmodule

[design/wsfd_queue.sv]
`timescale 1ns / 1ps

module wsfd_queue #(
    parameter int DEPTH = wsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wsfd_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output wsfd_pkg::t_entry    o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsfd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the incoming request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[design/wsfd_back.sv]
`timescale 1ns / 1ps

module wsfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  wsfd_pkg::t_entry    i_entry,
    output logic                o_take,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_payload_byte,
    output logic                o_has_data,
    output logic [3:0]          o_frame_opcode,
    output logic                o_frame_fin,
    output logic                o_frame_last
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic [3:0] r_opcode;
    logic       r_fin;
    logic       r_last;

    // Load the output register when it is free or being drained
    assign o_take = i_valid && (!r_valid || i_pop);

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Unmask the payload byte into the output register
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_byte   <= i_entry.data ^ i_entry.key;
            r_has    <= i_entry.has_data;
            r_opcode <= i_entry.opcode;
            r_fin    <= i_entry.fin;
            r_last   <= i_entry.last;
        end
    end

    assign o_empty        = !r_valid;
    assign o_payload_byte = r_byte;
    assign o_has_data     = r_has;
    assign o_frame_opcode = r_opcode;
    assign o_frame_fin    = r_fin;
    assign o_frame_last   = r_last;

endmodule

[design/websocket_frame_deframer_core.sv]
// A result is registered in the queue and then in the output register.
// Throughput: one stream byte per cycle while the queue is not full.
// A queue of QUEUE_DEPTH requests and one output register absorb pop stalls.
// Reset (synchronous, active low) returns the parser to the first header byte
// and empties the queue and output register.
`timescale 1ns / 1ps

module websocket_frame_deframer_core #(
    parameter int QUEUE_DEPTH = wsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_stream_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_payload_byte,
    output logic       o_has_data,
    output logic [3:0] o_frame_opcode,
    output logic       o_frame_fin,
    output logic       o_frame_last
);

    wsfd_pkg::t_entry front_entry;
    wsfd_pkg::t_entry queue_entry;
    logic             front_push;
    logic             queue_valid;
    logic             back_take;
    logic             take;

    // Accept a byte whenever the queue has room
    assign take = push && !full;

    wsfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_stream_byte),
        .o_push  (front_push),
        .o_entry (front_entry)
    );

    wsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .i_pop   (back_take),
        .o_full  (full),
        .o_valid (queue_valid),
        .o_entry (queue_entry)
    );

    wsfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (queue_valid),
        .i_entry        (queue_entry),
        .o_take         (back_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_payload_byte (o_payload_byte),
        .o_has_data     (o_has_data),
        .o_frame_opcode (o_frame_opcode),
        .o_frame_fin    (o_frame_fin),
        .o_frame_last   (o_frame_last)
    );

endmodule
